// ===== hw/rtl/isqrt_pkg.sv =====
// Shared types, widths and the seed function for the Newton square root unit.
`timescale 1ns / 1ps
`default_nettype none

package isqrt_pkg;

	localparam int RAD_W  = 32;
	localparam int ROOT_W = 16;
	localparam int DIV_W  = ROOT_W + 1;
	localparam int CNT_W  = $clog2(RAD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RES,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} isqrt_state_t;

	// Floor square root of an 8-bit value, as a count of squares not above it.
	function automatic logic [3:0] byte_isqrt(input logic [7:0] v);
		logic [3:0] r;
		r = 4'd0;
		for (int k = 1; k < 16; k++) begin
			if (v >= 8'(k * k)) begin
				r = r + 4'd1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_square_root_newton_unit.sv =====
// Top level of the integer square root unit: table seed, Newton steps, shared divider.
//
//   channel | ports                         | transfer
//   --------+-------------------------------+-------------------------------
//   input   | start, busy, radicand[31:0]   | start high while busy is low
//   result  | done, root[15:0]              | done high for one cycle
//
// Each Newton step runs one multiply, one subtract, the shared restoring divider
// (one quotient bit per cycle) and one update. The step count includes the final
// zero step (1 for a zero radicand, 5 for 0x0100_0000); a radicand whose seed
// overflows goes straight from transfer to the final state.
// Reset clears the sequencer and the done strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root_newton_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [isqrt_pkg::RAD_W-1:0] radicand,
	output logic                             done,
	output logic [isqrt_pkg::ROOT_W-1:0]     root
);

	import isqrt_pkg::*;

	isqrt_state_t state_q, state_d;

	logic [RAD_W-1:0]  n_q;
	logic [ROOT_W-1:0] d_q;
	logic [RAD_W-1:0]  prod_q;
	logic [RAD_W-1:0]  res_q;
	logic [RAD_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [ROOT_W-1:0] root_q;

	logic              accept;
	logic [15:0]       half_w;
	logic [7:0]        seed_byte;
	logic [3:0]        seed_sh;
	logic [4:0]        seed_base;
	logic [DIV_W-1:0]  seed;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    shifted;
	logic [ROOT_W-1:0] d_next;
	logic              stop;
	logic [DIV_W-1:0]  d_dec;

	assign accept = start && !busy;

	// Seed selection from the radicand.
	always_comb begin
		if (radicand[31:16] != 16'd0) begin
			half_w  = radicand[31:16];
			seed_sh = 4'd8;
		end else begin
			half_w  = radicand[15:0];
			seed_sh = 4'd0;
		end
		if (half_w[15:8] != 8'd0) begin
			seed_byte = half_w[15:8];
			seed_sh   = seed_sh + 4'd4;
		end else begin
			seed_byte = half_w[7:0];
		end
		seed_base = {1'b0, byte_isqrt(seed_byte)} + 5'd1;
		seed      = {12'd0, seed_base} << seed_sh;
	end

	// Restoring divider step and Newton update.
	always_comb begin
		shifted = {rem_q, quo_q[RAD_W-1]};
		trial   = shifted - {1'b0, div_q};
		d_next  = d_q - quo_q[ROOT_W-1:0];
		stop    = (quo_q == '0) || (d_next == '0);
		d_dec   = {1'b0, d_q} - DIV_W'(1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = seed[DIV_W-1] ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_RES;
			ST_RES: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD:  state_d = stop ? ST_FIN : ST_MUL;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q <= radicand;
					d_q <= seed[ROOT_W-1:0];
				end
			end
			ST_MUL: prod_q <= d_q * d_q;
			ST_RES: begin
				res_q <= prod_q - n_q;
				quo_q <= prod_q - n_q;
				rem_q <= '0;
				div_q <= {d_q, 1'b0};
				cnt_q <= '1;
			end
			ST_DIV: begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (!trial[DIV_W]) begin
					rem_q <= trial[DIV_W-1:0];
				end else begin
					rem_q <= shifted[DIV_W-1:0];
				end
				quo_q <= {quo_q[RAD_W-2:0], ~trial[DIV_W]};
			end
			ST_UPD: d_q <= d_next;
			ST_FIN: begin
				if ((d_q != '0) && (res_q >= RAD_W'(d_dec))) begin
					root_q <= d_dec[ROOT_W-1:0];
				end else begin
					root_q <= d_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign root = root_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while the unit is still busy");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted but the unit did not go busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("divider running with a zero divisor");

	a_seed_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (radicand[31:24] >= 8'hE1)) |-> ##2 (done && (root == '0)))
		else $error("seed overflow did not give a zero root in two cycles");

endmodule

`default_nettype wire
